FILE: hdl/gsbf_pkg.sv
// Shared types, constants and the CRC-32 byte function of the gzip stored-block framer.
`timescale 1ns / 1ps
package gsbf_pkg;

  localparam logic [1:0] REQ_BLOCK = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [7:0] OS_CODE_RST = 8'h03;
  localparam logic [7:0] GZ_ID1      = 8'h1F;
  localparam logic [7:0] GZ_ID2      = 8'h8B;
  localparam logic [7:0] GZ_CM       = 8'h08;

  // Byte positions inside a full member frame: gzip header, stored header, trailer.
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_ID1       = 5'd0;
  localparam logic [POS_W-1:0] POS_ID2       = 5'd1;
  localparam logic [POS_W-1:0] POS_CM        = 5'd2;
  localparam logic [POS_W-1:0] POS_OS        = 5'd9;
  localparam logic [POS_W-1:0] POS_BFINAL    = 5'd10;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 5'd11;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 5'd12;
  localparam logic [POS_W-1:0] POS_NLEN_LO   = 5'd13;
  localparam logic [POS_W-1:0] POS_NLEN_HI   = 5'd14;
  localparam logic [POS_W-1:0] POS_CRC0      = 5'd15;
  localparam logic [POS_W-1:0] POS_CRC1      = 5'd16;
  localparam logic [POS_W-1:0] POS_CRC2      = 5'd17;
  localparam logic [POS_W-1:0] POS_CRC3      = 5'd18;
  localparam logic [POS_W-1:0] POS_CNT0      = 5'd19;
  localparam logic [POS_W-1:0] POS_CNT1      = 5'd20;
  localparam logic [POS_W-1:0] POS_CNT2      = 5'd21;
  localparam logic [POS_W-1:0] POS_CNT3      = 5'd22;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ERR   = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_BLOCK = 2'd2,
    CMD_END   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        need_hdr;
    logic        need_blk;
    logic        fin;
    logic [15:0] len;
    logic [7:0]  data;
    logic [31:0] crc;
    logic [31:0] total;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int j = 0; j < 8; j++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

FILE: hdl/gsbf_queue.sv
// Command queue between the classifying front end and the byte sequencer.
`timescale 1ns / 1ps
module gsbf_queue import gsbf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full  = (count_r == Q_CW'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push_valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_valid && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");

endmodule

FILE: hdl/gsbf_front.sv
// Front end: accepts input words, checks their order, keeps member state and queues commands.
`timescale 1ns / 1ps
module gsbf_front import gsbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_block_length,
  input  logic        in_final_block,
  input  logic        q_full,
  output logic        push_valid,
  output cmd_t        push_cmd
);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] total_r, total_nxt;
  logic [15:0] left_r, left_nxt;
  logic        hdr_sent_r, hdr_sent_nxt;
  logic        fin_seen_r, fin_seen_nxt;
  logic        ok;
  logic        acc;

  assign in_ready   = !q_full;
  assign acc        = in_valid && in_ready;
  assign push_valid = acc;

  always_comb begin
    unique case (in_req_type)
      REQ_BLOCK: ok = (left_r == '0) && !fin_seen_r;
      REQ_DATA:  ok = (left_r != '0);
      REQ_END:   ok = (left_r == '0);
      default:   ok = 1'b0;
    endcase
  end

  always_comb begin
    push_cmd          = '0;
    push_cmd.need_hdr = !hdr_sent_r;
    push_cmd.data     = in_data_byte;
    push_cmd.crc      = crc_r ^ ALL_ONES;
    push_cmd.total    = total_r;
    if (!ok) begin
      push_cmd.kind = CMD_ERR;
    end else begin
      unique case (in_req_type)
        REQ_BLOCK: begin
          push_cmd.kind     = CMD_BLOCK;
          push_cmd.need_blk = 1'b1;
          push_cmd.fin      = in_final_block;
          push_cmd.len      = in_block_length;
        end
        REQ_DATA: begin
          push_cmd.kind = CMD_DATA;
        end
        default: begin
          // empty final block when the stream had none
          push_cmd.kind     = CMD_END;
          push_cmd.need_blk = !fin_seen_r;
          push_cmd.fin      = 1'b1;
          push_cmd.len      = '0;
        end
      endcase
    end
  end

  always_comb begin
    crc_nxt      = crc_r;
    total_nxt    = total_r;
    left_nxt     = left_r;
    hdr_sent_nxt = hdr_sent_r;
    fin_seen_nxt = fin_seen_r;
    if (acc && ok) begin
      unique case (in_req_type)
        REQ_BLOCK: begin
          hdr_sent_nxt = 1'b1;
          left_nxt     = in_block_length;
          fin_seen_nxt = fin_seen_r || in_final_block;
        end
        REQ_DATA: begin
          crc_nxt   = crc_byte(crc_r, in_data_byte);
          total_nxt = total_r + 32'd1;
          left_nxt  = left_r - 16'd1;
        end
        default: begin
          crc_nxt      = ALL_ONES;
          total_nxt    = '0;
          left_nxt     = '0;
          hdr_sent_nxt = 1'b0;
          fin_seen_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= ALL_ONES;
      total_r    <= '0;
      left_r     <= '0;
      hdr_sent_r <= 1'b0;
      fin_seen_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      total_r    <= total_nxt;
      left_r     <= left_nxt;
      hdr_sent_r <= hdr_sent_nxt;
      fin_seen_r <= fin_seen_nxt;
    end
  end

  a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ok && in_req_type == REQ_END) |=>
      (!hdr_sent_r && !fin_seen_r && left_r == '0 && total_r == '0))
    else $error("member state not rearmed after stream end");
  a_final_has_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    fin_seen_r |-> hdr_sent_r) else $error("final block without gzip header");

endmodule

FILE: hdl/gsbf_back.sv
// Back end: walks the queued command byte by byte into the output register.
`timescale 1ns / 1ps
module gsbf_back import gsbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       head,
  output logic       pop,
  input  logic [7:0] os_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_status
);

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_status_r, out_status_nxt;
  logic             started_r, started_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] start_pos, pos, next_pos;
  logic             adv, emit, last;
  logic [7:0]       frame_byte;

  assign adv  = !out_valid_r || out_ready;
  assign emit = adv && !q_empty;
  assign pop  = emit && last;

  assign start_pos = head.need_hdr ? POS_ID1 : (head.need_blk ? POS_BFINAL : POS_CRC0);
  assign pos       = started_r ? pos_r : start_pos;
  assign next_pos  = (pos == POS_OS) ? (head.need_blk ? POS_BFINAL : POS_CRC0)
                                     : pos + 1'b1;

  always_comb begin
    unique case (head.kind)
      CMD_BLOCK: last = (pos == POS_NLEN_HI);
      CMD_END:   last = (pos == POS_CNT3);
      default:   last = 1'b1;
    endcase
  end

  always_comb begin
    unique case (pos)
      POS_ID1:     frame_byte = GZ_ID1;
      POS_ID2:     frame_byte = GZ_ID2;
      POS_CM:      frame_byte = GZ_CM;
      POS_OS:      frame_byte = os_code;
      POS_BFINAL:  frame_byte = {7'h0, head.fin};
      POS_LEN_LO:  frame_byte = head.len[7:0];
      POS_LEN_HI:  frame_byte = head.len[15:8];
      POS_NLEN_LO: frame_byte = ~head.len[7:0];
      POS_NLEN_HI: frame_byte = ~head.len[15:8];
      POS_CRC0:    frame_byte = head.crc[7:0];
      POS_CRC1:    frame_byte = head.crc[15:8];
      POS_CRC2:    frame_byte = head.crc[23:16];
      POS_CRC3:    frame_byte = head.crc[31:24];
      POS_CNT0:    frame_byte = head.total[7:0];
      POS_CNT1:    frame_byte = head.total[15:8];
      POS_CNT2:    frame_byte = head.total[23:16];
      POS_CNT3:    frame_byte = head.total[31:24];
      default:     frame_byte = 8'h00;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    started_nxt    = started_r;
    pos_nxt        = pos_r;
    if (adv) begin
      out_valid_nxt = !q_empty;
    end
    if (emit) begin
      out_last_nxt   = last;
      out_status_nxt = (head.kind == CMD_ERR);
      unique case (head.kind)
        CMD_ERR:  out_byte_nxt = 8'h00;
        CMD_DATA: out_byte_nxt = head.data;
        default:  out_byte_nxt = frame_byte;
      endcase
      started_nxt = !last;
      pos_nxt     = next_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    pos_r        <= pos_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_status      = out_status_r;

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_last_r && out_byte_r == 8'h00))
    else $error("error word not a single zero byte");
  a_run_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> !q_empty) else $error("run in progress with empty queue");

endmodule

FILE: hdl/gzip_stored_block_framer_core.sv
// Top level of the gzip stored-block framer: front end, command queue, byte sequencer.
`timescale 1ns / 1ps
// Each input word is checked and folded into the member state (CRC-32, byte count,
// open block length) in the cycle it is accepted, and a command goes into a four-entry
// queue; the sequencer then sends one output byte per cycle while out_ready is high.
// A data word costs one output word, so data streams at one byte per clock when the
// output is not stalled. A block start produces 5 bytes (15 with the gzip header) and
// a stream end 8 to 23 bytes, one per cycle; the front keeps accepting words until the
// queue fills. A misordered word yields one zero byte with status set and changes no
// state. The OS byte register should be written only while no output is pending.
module gzip_stored_block_framer_core import gsbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_block_length,
  input  logic        in_final_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_os_code
);

  logic [7:0] os_code_r;
  logic       push_valid;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  cmd_t       head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      os_code_r <= OS_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      os_code_r <= cfg_os_code;
    end
  end

  gsbf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_data_byte    (in_data_byte),
    .in_block_length (in_block_length),
    .in_final_block  (in_final_block),
    .q_full          (q_full),
    .push_valid      (push_valid),
    .push_cmd        (push_cmd)
  );

  gsbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  gsbf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .os_code         (os_code_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_status      (out_status)
  );

endmodule
